// ===== hw/rtl/snwc_pkg.sv =====
// shared types, constants and codes for the sprite nibble write combiner
// no dependencies
package snwc_pkg;

   localparam logic [1:0] OP_NEW_LINE = 2'd0;
   localparam logic [1:0] OP_PIXEL    = 2'd1;
   localparam logic [1:0] OP_FLUSH    = 2'd2;

   localparam logic [2:0] ST_BACKGROUND  = 3'd0;
   localparam logic [2:0] ST_BACK_NONCOL = 3'd1;
   localparam logic [2:0] ST_BACK_SHADOW = 3'd2;
   localparam logic [2:0] ST_BOUNDARY    = 3'd3;
   localparam logic [2:0] ST_NORMAL      = 3'd4;
   localparam logic [2:0] ST_XOR         = 3'd6;

   localparam logic [2:0] SPRITE_TYPE_RESET = ST_NORMAL;

   localparam logic [3:0] PEN_CLEAR = 4'h0;
   localparam logic [3:0] PEN_FULL  = 4'hf;

   localparam logic REG_SPRITE_TYPE = 1'b0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] line_address;
      logic [7:0]  hpos;
      logic [3:0]  pixel_value;
   } req_type;

   typedef struct packed {
      logic [7:0]  mem_value;
      logic        do_xor;
      logic        do_modify;
      logic        do_write;
      logic        left_mask;
      logic        right_mask;
      logic [15:0] mem_address;
   } rsp_type;

   typedef struct packed {
      logic fl_right;
      logic fl_left;
      logic fl_write;
      logic fl_modify;
      logic fl_xor;
   } flags_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] line_address;
      logic [6:0]  offset;
      logic [7:0]  value;
      flags_type   flags_edge;
      flags_type   flags_plain;
   } cls_type;

   typedef struct packed {
      logic                full;
      logic                empty;
      logic [QUEUE_AW:0]   count;
   } queue_status_type;

endpackage

// ===== hw/rtl/snwc_front.sv =====
// front end: classifies each accepted beat by sprite type and pen
// depends on snwc_pkg
module snwc_front (
   input  snwc_pkg::req_type req_data,
   input  logic [2:0]        sprite_type,
   output snwc_pkg::cls_type cls
);

   logic              right;
   logic              opaque;
   logic [7:0]        value;
   snwc_pkg::flags_type side;
   snwc_pkg::flags_type modify_f;
   snwc_pkg::flags_type write_f;

   assign right = req_data.hpos[0];
   assign value = right ? {4'h0, req_data.pixel_value} : {req_data.pixel_value, 4'h0};

   always_comb begin
      side = '0;
      side.fl_right = right;
      side.fl_left  = !right;
      modify_f = side;
      modify_f.fl_modify = 1'b1;
      write_f = side;
      write_f.fl_write = 1'b1;
   end

   always_comb begin
      case (sprite_type)
         snwc_pkg::ST_BACKGROUND, snwc_pkg::ST_BACK_NONCOL: begin
            opaque = 1'b1;
         end
         snwc_pkg::ST_BACK_SHADOW, snwc_pkg::ST_BOUNDARY: begin
            opaque = (req_data.pixel_value != snwc_pkg::PEN_CLEAR) &&
                     (req_data.pixel_value != snwc_pkg::PEN_FULL);
         end
         default: begin
            opaque = (req_data.pixel_value != snwc_pkg::PEN_CLEAR);
         end
      endcase
   end

   always_comb begin
      cls.operation    = req_data.operation;
      cls.line_address = req_data.line_address;
      cls.offset       = req_data.hpos[7:1];
      cls.value        = value;
      cls.flags_edge   = '0;
      cls.flags_plain  = '0;
      if (sprite_type == snwc_pkg::ST_XOR) begin
         cls.flags_edge.fl_xor  = 1'b1;
         cls.flags_plain.fl_xor = 1'b1;
      end else if (!opaque) begin
         cls.value = '0;
      end else begin
         cls.flags_edge = modify_f;
         if (sprite_type == snwc_pkg::ST_BACKGROUND ||
             sprite_type == snwc_pkg::ST_BACK_NONCOL) begin
            cls.flags_plain = write_f;
         end else begin
            cls.flags_plain = modify_f;
         end
      end
   end

endmodule

// ===== hw/rtl/snwc_queue.sv =====
// short queue of classified beats between front and back
// depends on snwc_pkg
module snwc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  snwc_pkg::cls_type          push_data,
   input  logic                       pop,
   output snwc_pkg::cls_type          pop_data,
   output snwc_pkg::queue_status_type status
);

   snwc_pkg::cls_type entry_ff [snwc_pkg::QUEUE_DEPTH];
   logic [snwc_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [snwc_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [snwc_pkg::QUEUE_AW:0]   count_ff, count_in;
   logic                          do_push;
   logic                          do_pop;

   assign status.count = count_ff;
   assign status.full  = (count_ff == (snwc_pkg::QUEUE_AW+1)'(snwc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hw/rtl/snwc_back.sv =====
// back end: held byte operation, merge and emit, result register
// depends on snwc_pkg
module snwc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  snwc_pkg::cls_type q_data,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output snwc_pkg::rsp_type rsp_data
);

   logic [15:0]         line_base_ff, line_base_in;
   logic [6:0]          held_offset_ff, held_offset_in;
   logic [7:0]          held_value_ff, held_value_in;
   snwc_pkg::flags_type held_flags_ff, held_flags_in;
   logic                edge_pending_ff, edge_pending_in;
   logic                out_valid_ff, out_valid_in;
   snwc_pkg::rsp_type   out_data_ff, out_data_in;
   snwc_pkg::rsp_type   result;
   snwc_pkg::flags_type emit_flags;
   logic                emit;
   logic                advance;

   assign advance   = !q_empty && (!out_valid_ff || rsp_pop);
   assign q_pop     = advance;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_data_ff;

   always_comb begin
      line_base_in    = line_base_ff;
      held_offset_in  = held_offset_ff;
      held_value_in   = held_value_ff;
      held_flags_in   = held_flags_ff;
      edge_pending_in = edge_pending_ff;
      emit            = 1'b0;
      emit_flags      = held_flags_ff;
      case (q_data.operation)
         snwc_pkg::OP_NEW_LINE: begin
            line_base_in    = q_data.line_address;
            held_value_in   = '0;
            held_flags_in   = '0;
            edge_pending_in = 1'b1;
         end
         snwc_pkg::OP_PIXEL: begin
            if (edge_pending_ff) begin
               held_offset_in  = q_data.offset;
               held_value_in   = q_data.value;
               held_flags_in   = q_data.flags_edge;
               edge_pending_in = 1'b0;
            end else if (held_offset_ff == q_data.offset) begin
               held_value_in = held_value_ff | q_data.value;
               held_flags_in = held_flags_ff | q_data.flags_plain;
            end else begin
               emit           = 1'b1;
               held_offset_in = q_data.offset;
               held_value_in  = q_data.value;
               held_flags_in  = q_data.flags_plain;
            end
         end
         snwc_pkg::OP_FLUSH: begin
            held_flags_in.fl_modify = 1'b1;
            emit_flags.fl_modify    = 1'b1;
            emit                    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result = '0;
      if (emit) begin
         result.mem_value   = held_value_ff;
         result.do_xor      = emit_flags.fl_xor;
         result.do_modify   = emit_flags.fl_modify;
         result.do_write    = emit_flags.fl_write;
         result.left_mask   = emit_flags.fl_left;
         result.right_mask  = emit_flags.fl_right;
         result.mem_address = line_base_ff + {9'd0, held_offset_ff};
      end
   end

   always_comb begin
      out_data_in  = advance ? result : out_data_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_base_ff    <= '0;
         held_offset_ff  <= '0;
         held_value_ff   <= '0;
         held_flags_ff   <= '0;
         edge_pending_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            line_base_ff    <= line_base_in;
            held_offset_ff  <= held_offset_in;
            held_value_ff   <= held_value_in;
            held_flags_ff   <= held_flags_in;
            edge_pending_ff <= edge_pending_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff <= out_data_in;
   end

endmodule

// ===== hw/rtl/sprite_nibble_write_combiner.sv =====
// sprite nibble write combiner top level: one result beat per accepted beat
// a beat is written into the queue when it is accepted, then moves from the queue head
// into the result register; throughput one beat per cycle while rsp_pop keeps the result
// register from being held, as the merge step in the back end is combinational
// synchronous active-high reset empties queue and result register and clears held state,
// sprite type resets to normal; depends on snwc_pkg, snwc_front, snwc_queue, snwc_back
module sprite_nibble_write_combiner (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  snwc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output snwc_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [2:0]                 sprite_type_ff, sprite_type_in;
   logic                       csr_write;
   snwc_pkg::cls_type          cls;
   snwc_pkg::cls_type          q_data;
   snwc_pkg::queue_status_type q_status;
   logic                       q_pop;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == snwc_pkg::REG_SPRITE_TYPE) ?
                       {29'd0, sprite_type_ff} : 32'd0;

   always_comb begin
      sprite_type_in = sprite_type_ff;
      if (csr_write && csr_paddr[2] == snwc_pkg::REG_SPRITE_TYPE) begin
         sprite_type_in = csr_pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sprite_type_ff <= snwc_pkg::SPRITE_TYPE_RESET;
      end else begin
         sprite_type_ff <= sprite_type_in;
      end
   end

   assign req_full = q_status.full;

   snwc_front u_front (
      .req_data    (req_data),
      .sprite_type (sprite_type_ff),
      .cls         (cls)
   );

   snwc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (cls),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   snwc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_status.empty),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   // full flag tracks the fill count
   assert property (@(posedge clock) disable iff (reset)
      req_full == (q_status.count == (snwc_pkg::QUEUE_AW+1)'(snwc_pkg::QUEUE_DEPTH)))
      else $error("queue full flag disagrees with count");

   // fill count moves by at most one per cycle
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (q_status.count == $past(q_status.count) ||
                         q_status.count == $past(q_status.count) + 1'b1 ||
                         q_status.count == $past(q_status.count) - 1'b1))
      else $error("queue count jumped");

   // nothing on the result side right after reset
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> rsp_empty)
      else $error("result beat present after reset");

   // a sprite type write lands in the register
   assert property (@(posedge clock) disable iff (reset)
      csr_write && csr_paddr[2] == snwc_pkg::REG_SPRITE_TYPE |=>
         sprite_type_ff == $past(csr_pwdata[2:0]))
      else $error("sprite type write lost");

endmodule

// ===== sim/snwc_checker.sv =====
// result checker for the sprite nibble write combiner: watches the request, result
// and csr channels, predicts every result beat and compares it field by field
// depends on snwc_pkg
`timescale 1ns / 100ps

module snwc_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  snwc_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  snwc_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   input  logic              csr_pready,
   output int                outstanding,
   output int                failures
);

   logic [2:0]          sprite_type;
   logic [15:0]         line_base;
   logic [6:0]          held_offset;
   logic [7:0]          held_value;
   snwc_pkg::flags_type held_flags;
   logic                edge_pending;
   snwc_pkg::rsp_type   expected_ops[$];
   int                  mismatches;

   function automatic void pen_operation(input logic [3:0] pen, input logic right,
                                         input logic at_edge, output logic [7:0] value,
                                         output snwc_pkg::flags_type flags);
      logic opaque;
      value = right ? {4'h0, pen} : {pen, 4'h0};
      flags = '0;
      case (sprite_type)
         snwc_pkg::ST_BACK_SHADOW, snwc_pkg::ST_BOUNDARY:
            opaque = (pen != snwc_pkg::PEN_CLEAR) && (pen != snwc_pkg::PEN_FULL);
         snwc_pkg::ST_BACKGROUND, snwc_pkg::ST_BACK_NONCOL: opaque = 1'b1;
         default: opaque = (pen != snwc_pkg::PEN_CLEAR);
      endcase
      if (sprite_type == snwc_pkg::ST_XOR) begin
         flags.fl_xor = 1'b1;
      end else if (!opaque) begin
         value = '0;
      end else begin
         if (!at_edge && (sprite_type == snwc_pkg::ST_BACKGROUND ||
                          sprite_type == snwc_pkg::ST_BACK_NONCOL))
            flags.fl_write = 1'b1;
         else
            flags.fl_modify = 1'b1;
         if (right)
            flags.fl_right = 1'b1;
         else
            flags.fl_left = 1'b1;
      end
   endfunction

   function automatic snwc_pkg::rsp_type held_operation();
      snwc_pkg::rsp_type op;
      op.mem_value   = held_value;
      op.do_xor      = held_flags.fl_xor;
      op.do_modify   = held_flags.fl_modify;
      op.do_write    = held_flags.fl_write;
      op.left_mask   = held_flags.fl_left;
      op.right_mask  = held_flags.fl_right;
      op.mem_address = line_base + {9'd0, held_offset};
      return op;
   endfunction

   // advances the combiner state by one request beat, returns its result beat
   function automatic snwc_pkg::rsp_type combine_beat(input snwc_pkg::req_type beat);
      snwc_pkg::rsp_type   result;
      logic [7:0]          value;
      snwc_pkg::flags_type flags;
      logic [6:0]          offset;
      result = '0;
      offset = beat.hpos[7:1];
      case (beat.operation)
         snwc_pkg::OP_NEW_LINE: begin
            line_base = beat.line_address;
            held_value = '0;
            held_flags = '0;
            edge_pending = 1'b1;
         end
         snwc_pkg::OP_PIXEL: begin
            pen_operation(beat.pixel_value, beat.hpos[0], edge_pending, value, flags);
            if (edge_pending) begin
               held_offset = offset;
               held_value = value;
               held_flags = flags;
               edge_pending = 1'b0;
            end else if (held_offset == offset) begin
               held_value = held_value | value;
               held_flags = snwc_pkg::flags_type'(held_flags | flags);
            end else begin
               result = held_operation();
               held_offset = offset;
               held_value = value;
               held_flags = flags;
            end
         end
         snwc_pkg::OP_FLUSH: begin
            held_flags.fl_modify = 1'b1;
            result = held_operation();
         end
         default: ;
      endcase
      return result;
   endfunction

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      snwc_pkg::rsp_type want;
      if (reset) begin
         expected_ops.delete();
         sprite_type = snwc_pkg::SPRITE_TYPE_RESET;
         line_base = '0;
         held_offset = '0;
         held_value = '0;
         held_flags = '0;
         edge_pending = 1'b0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == snwc_pkg::REG_SPRITE_TYPE)
            sprite_type = csr_pwdata[2:0];
         if (rsp_pop && !rsp_empty) begin
            if (expected_ops.size() == 0) begin
               mismatches++;
               $error("result beat 0x%0h with nothing expected", rsp_data);
            end else begin
               want = expected_ops.pop_front();
               compare_field("mem_value", 32'(want.mem_value), 32'(rsp_data.mem_value));
               compare_field("do_xor", 32'(want.do_xor), 32'(rsp_data.do_xor));
               compare_field("do_modify", 32'(want.do_modify), 32'(rsp_data.do_modify));
               compare_field("do_write", 32'(want.do_write), 32'(rsp_data.do_write));
               compare_field("left_mask", 32'(want.left_mask), 32'(rsp_data.left_mask));
               compare_field("right_mask", 32'(want.right_mask),
                             32'(rsp_data.right_mask));
               compare_field("mem_address", 32'(want.mem_address),
                             32'(rsp_data.mem_address));
            end
         end
         if (req_push && !req_full)
            expected_ops.push_back(combine_beat(req_data));
      end
      outstanding <= expected_ops.size();
      failures <= mismatches;
   end

endmodule

// ===== sim/tb_sprite_nibble_write_combiner.sv =====
// testbench top for the sprite nibble write combiner: clock, reset, directed and
// random request beats, csr writes of every sprite type, random result stalls
// depends on snwc_pkg, sprite_nibble_write_combiner and snwc_checker
`timescale 1ns / 100ps

module tb_sprite_nibble_write_combiner;

   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam logic [2:0] ST_NONCOL   = 3'd5;
   localparam logic [2:0] ST_SHADOW   = 3'd7;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         PHASE_BEATS = 90;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   snwc_pkg::req_type req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop = 1'b0;
   snwc_pkg::rsp_type rsp_data;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [2:0]        csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int outstanding;
   int failures;
   int idle_odds = 0;
   int pop_stall = 0;
   int beats_sent = 0;
   int cycle_count = 0;

   logic [2:0] sprite_plan [8] = '{snwc_pkg::ST_BACKGROUND, ST_SHADOW,
                                   snwc_pkg::ST_BACK_NONCOL, snwc_pkg::ST_BACK_SHADOW,
                                   snwc_pkg::ST_BOUNDARY, snwc_pkg::ST_XOR, ST_NONCOL,
                                   snwc_pkg::ST_NORMAL};

   sprite_nibble_write_combiner uut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   snwc_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .outstanding (outstanding),
      .failures    (failures)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // result side stalls
   always @(posedge clock) begin
      if (pop_stall > 0) begin
         pop_stall <= pop_stall - 1;
         rsp_pop <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         pop_stall <= $urandom_range(0, 13);
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sprite_nibble_write_combiner verification failed");
      $finish;
   end

   function automatic logic [3:0] random_pen();
      case ($urandom_range(0, 3))
         0: return snwc_pkg::PEN_CLEAR;
         1: return snwc_pkg::PEN_FULL;
         default: return 4'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic send_op(input logic [1:0] op, input logic [15:0] addr,
                          input logic [7:0] xpos, input logic [3:0] pen);
      snwc_pkg::req_type beat;
      beat.operation = op;
      beat.line_address = addr;
      beat.hpos = xpos;
      beat.pixel_value = pen;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_data <= beat;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      beats_sent++;
   endtask

   task automatic drain_results();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic program_sprite_type(input logic [2:0] value);
      drain_results();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {snwc_pkg::REG_SPRITE_TYPE, 2'b00};
      csr_pwdata <= {29'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // mostly whole lines of walking pixels, some noise beats
   task automatic send_random_mix(input int count);
      int         stop_at;
      int         run;
      logic [7:0] xpos;
      stop_at = beats_sent + count;
      while (beats_sent < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            send_op(snwc_pkg::OP_NEW_LINE, 16'($urandom), 8'($urandom), 4'($urandom));
            xpos = 8'($urandom);
            run = $urandom_range(2, 14);
            repeat (run) begin
               send_op(snwc_pkg::OP_PIXEL, 16'($urandom), xpos, random_pen());
               case ($urandom_range(0, 5))
                  0: xpos = xpos ^ 8'd1;
                  1, 2: xpos = xpos + 8'd1;
                  3: xpos = xpos + 8'd2;
                  4: xpos = xpos - 8'd1;
                  default: xpos = 8'($urandom);
               endcase
               if ($urandom_range(0, 9) == 0)
                  send_op(snwc_pkg::OP_FLUSH, 16'($urandom), 8'($urandom), 4'($urandom));
            end
            if ($urandom_range(0, 2) != 0)
               send_op(snwc_pkg::OP_FLUSH, 16'($urandom), 8'($urandom), 4'($urandom));
         end else begin
            send_op(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom), 4'($urandom));
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 5;

      // reset sprite type is normal; pixels ahead of any new line
      send_op(snwc_pkg::OP_PIXEL, 16'h0000, 8'd0, 4'd5);
      send_op(snwc_pkg::OP_PIXEL, 16'hffff, 8'd3, snwc_pkg::PEN_FULL);
      send_op(OP_UNUSED, 16'hffff, 8'hff, 4'hf);
      // address wrap at the top of the line
      send_op(snwc_pkg::OP_NEW_LINE, 16'hffff, 8'd0, 4'd0);
      send_op(snwc_pkg::OP_PIXEL, 16'h0000, 8'd255, snwc_pkg::PEN_CLEAR);
      send_op(snwc_pkg::OP_PIXEL, 16'h0000, 8'd254, snwc_pkg::PEN_FULL);
      send_op(snwc_pkg::OP_FLUSH, 16'h0000, 8'd0, 4'd0);
      send_op(snwc_pkg::OP_PIXEL, 16'h0000, 8'd0, 4'd9);
      send_op(snwc_pkg::OP_NEW_LINE, 16'h0000, 8'hff, 4'hf);
      send_op(snwc_pkg::OP_PIXEL, 16'hffff, 8'd0, snwc_pkg::PEN_FULL);
      send_op(snwc_pkg::OP_PIXEL, 16'hffff, 8'd1, 4'd1);
      send_op(snwc_pkg::OP_PIXEL, 16'hffff, 8'd2, snwc_pkg::PEN_CLEAR);
      send_op(snwc_pkg::OP_FLUSH, 16'hffff, 8'hff, 4'hf);
      send_op(snwc_pkg::OP_FLUSH, 16'h0000, 8'd0, 4'd0);
      // back to back new lines, flush of an empty held beat, edge pixel after it
      send_op(snwc_pkg::OP_NEW_LINE, 16'h8001, 8'd0, 4'd0);
      send_op(snwc_pkg::OP_NEW_LINE, 16'h1234, 8'd0, 4'd0);
      send_op(snwc_pkg::OP_FLUSH, 16'h0000, 8'd0, 4'd0);
      send_op(snwc_pkg::OP_PIXEL, 16'h0000, 8'd128, 4'd8);
      send_op(snwc_pkg::OP_PIXEL, 16'h0000, 8'd130, 4'd7);

      for (int phase = 0; phase < 8; phase++) begin
         program_sprite_type(sprite_plan[phase]);
         if (phase == 7)
            idle_odds = 0;
         else
            idle_odds = (phase % 3 == 0) ? 4 : ((phase % 3 == 1) ? 0 : 12);
         send_random_mix(PHASE_BEATS);
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (failures == 0)
         $display("sprite_nibble_write_combiner verification clean");
      else
         $display("sprite_nibble_write_combiner verification failed");
      $finish;
   end

endmodule
